// ----- design/hdfa_pkg.sv -----
// Package for the header-delimited frame assembler.
// Holds the buffer sizing constants, the chunk mode and register codes and the
// structs that pass between the front, the descriptor queue and the back.
`timescale 1ns / 1ps

package hdfa_pkg;

    // Bytes in one message buffer; the design holds two such banks.
    localparam int BUF_BYTES  = 32;
    localparam int IDX_W      = $clog2(BUF_BYTES);
    localparam int FILL_W     = $clog2(BUF_BYTES + 1);
    localparam int ADDR_W     = IDX_W + 1;
    localparam int MEM_DEPTH  = 2 * (2 ** IDX_W);
    localparam int MSG_LEN_W  = 6;

    localparam logic [7:0] HDR_FIRST_RST  = 8'h4D;
    localparam logic [7:0] HDR_SECOND_RST = 8'h42;

    typedef enum logic {
        CFG_HDR_FIRST  = 1'b0,
        CFG_HDR_SECOND = 1'b1
    } t_cfg_index;

    typedef enum logic [3:0] {
        MODE_IDLE   = 4'b0001,
        MODE_HOLD   = 4'b0010,
        MODE_APPEND = 4'b0100,
        MODE_JUNK   = 4'b1000
    } t_chunk_mode;

    typedef enum logic [2:0] {
        BK_IDLE = 3'b001,
        BK_READ = 3'b010,
        BK_LOAD = 3'b100
    } t_back_state;

    typedef struct packed {
        logic              bank;
        logic [FILL_W-1:0] len;
    } t_desc;

    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_push;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

// ----- design/header_delimited_frame_assembler.sv -----
// Header-delimited frame assembler: received chunk bytes in, message bytes out.
// The input channel (i_in_valid / o_in_stall) carries one chunk byte per
// transaction with its chunk-start mark and the chunk length. A chunk of two
// to 32 bytes that opens with the two configured header bytes starts a new
// message and flushes any open one; other chunks append to an open message or
// are dropped. A full buffer is flushed at once.
// The output channel (o_out_valid / i_out_stall) carries one message byte per
// transaction, with a last mark and the message length.
// The front takes a new byte only while no buffer write or flush is pending,
// as the buffer memory has a single write port; a header that closes an open
// message also flushes it. The front switches between two buffer banks and
// waits only when the next bank is still draining. A closed message's
// descriptor is queued; the back reads its first byte (BK_READ) and loads it
// (BK_LOAD), and the rest follow one per cycle while the receiver takes them.
// Reset (synchronous, active low) closes any message and restores the header
// bytes 0x4D, 0x42; it needs no clearing pass. While the receiver stalls, the
// output byte holds and the draining bank stays busy.
`timescale 1ns / 1ps

module header_delimited_frame_assembler import hdfa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_chunk_start,
    input  logic [7:0]           i_chunk_length,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_msg_byte,
    output logic                 o_msg_last,
    output logic [MSG_LEN_W-1:0] o_msg_length
);

    t_mem_wr  mem_wr;
    t_push    push;
    t_release release_bank;
    t_desc    head;
    logic     not_empty;
    logic     pop;

    hdfa_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_data_byte    (i_data_byte),
        .i_chunk_start  (i_chunk_start),
        .i_chunk_length (i_chunk_length),
        .o_mem_wr       (mem_wr),
        .o_push         (push),
        .i_release      (release_bank)
    );

    hdfa_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop       (pop),
        .o_head      (head),
        .o_not_empty (not_empty)
    );

    hdfa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mem_wr     (mem_wr),
        .i_head       (head),
        .i_not_empty  (not_empty),
        .o_pop        (pop),
        .o_release    (release_bank),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_msg_byte   (o_msg_byte),
        .o_msg_last   (o_msg_last),
        .o_msg_length (o_msg_length)
    );

endmodule

// ----- design/hdfa_front.sv -----
// Front part of the frame assembler: accepts input bytes, tracks chunk state,
// decides header, append or drop, and writes message bytes into the buffer banks.
// Depends on hdfa_pkg.
`timescale 1ns / 1ps

module hdfa_front import hdfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_chunk_start,
    input  logic [7:0]  i_chunk_length,
    output t_mem_wr     o_mem_wr,
    output t_push       o_push,
    input  t_release    i_release
);

    localparam logic [FILL_W-1:0] FILL_NEAR1 = FILL_W'(BUF_BYTES - 1);
    localparam logic [FILL_W-1:0] FILL_NEAR2 = FILL_W'(BUF_BYTES - 2);
    localparam logic [8:0]        LEN_LIMIT  = 9'(BUF_BYTES);

    logic [7:0]        r_hdr_first, r_hdr_second;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_held, n_held;
    logic [7:0]        r_left, n_left;
    t_chunk_mode       r_mode, n_mode;
    logic              r_active, n_active;
    logic [1:0]        r_busy, n_busy;
    logic              r_op_flush, n_op_flush;
    logic [1:0]        r_op_cnt, n_op_cnt;
    logic [7:0]        r_op_b0, n_op_b0;
    logic [7:0]        r_op_b1, n_op_b1;
    logic              accept;

    assign o_in_stall = r_op_flush || (r_op_cnt != 2'd0);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        t_chunk_mode m;
        logic [7:0]  left_new;
        m          = r_mode;
        left_new   = r_left;
        n_fill     = r_fill;
        n_held     = r_held;
        n_left     = r_left;
        n_mode     = r_mode;
        n_active   = r_active;
        n_op_flush = r_op_flush;
        n_op_cnt   = r_op_cnt;
        n_op_b0    = r_op_b0;
        n_op_b1    = r_op_b1;
        n_busy     = r_busy;
        o_mem_wr.en   = 1'b0;
        o_mem_wr.addr = {r_active, r_fill[IDX_W-1:0]};
        o_mem_wr.data = r_op_b0;
        o_push.valid     = 1'b0;
        o_push.desc.bank = r_active;
        o_push.desc.len  = r_fill;

        if (i_release.valid) begin
            n_busy[i_release.bank] = 1'b0;
        end

        if (accept) begin
            if (i_chunk_start) begin
                if (i_chunk_length == 8'd0) begin
                    n_mode = MODE_IDLE;
                    n_left = 8'd0;
                end else begin
                    left_new = i_chunk_length - 8'd1;
                    if ({1'b0, i_chunk_length} > LEN_LIMIT) begin
                        m = MODE_JUNK;
                    end else if (i_chunk_length >= 8'd2) begin
                        n_held = i_data_byte;
                        m      = MODE_HOLD;
                    end else if (r_fill != '0) begin
                        n_op_cnt = 2'd1;
                        n_op_b0  = i_data_byte;
                        m        = (r_fill == FILL_NEAR1) ? MODE_JUNK : MODE_APPEND;
                    end else begin
                        m = MODE_JUNK;
                    end
                    n_left = left_new;
                    n_mode = (left_new == 8'd0) ? MODE_IDLE : m;
                end
            end else if (r_mode == MODE_IDLE || r_left == 8'd0) begin
                n_mode = MODE_IDLE;
            end else begin
                left_new = r_left - 8'd1;
                unique case (r_mode)
                    MODE_HOLD: begin
                        if (r_held == r_hdr_first && i_data_byte == r_hdr_second) begin
                            // A header closes any open message before the new one starts.
                            n_op_flush = (r_fill != '0);
                            n_op_cnt   = 2'd2;
                            n_op_b0    = r_held;
                            n_op_b1    = i_data_byte;
                            m          = MODE_APPEND;
                        end else if (r_fill != '0) begin
                            n_op_cnt = 2'd2;
                            n_op_b0  = r_held;
                            n_op_b1  = i_data_byte;
                            m = (r_fill == FILL_NEAR1 || r_fill == FILL_NEAR2) ?
                                MODE_JUNK : MODE_APPEND;
                        end else begin
                            m = MODE_JUNK;
                        end
                    end
                    MODE_APPEND: begin
                        n_op_cnt = 2'd1;
                        n_op_b0  = i_data_byte;
                        m        = (r_fill == FILL_NEAR1) ? MODE_JUNK : MODE_APPEND;
                    end
                    MODE_JUNK: m = MODE_JUNK;
                    MODE_IDLE: m = MODE_IDLE;
                    default:   m = MODE_IDLE;
                endcase
                n_left = left_new;
                n_mode = (left_new == 8'd0) ? MODE_IDLE : m;
            end
        end else if (r_op_flush) begin
            n_op_flush = 1'b0;
            if (r_fill != '0) begin
                o_push.valid     = 1'b1;
                n_busy[r_active] = 1'b1;
                n_active         = !r_active;
                n_fill           = '0;
            end
        end else if (r_op_cnt != 2'd0 && !r_busy[r_active]) begin
            o_mem_wr.en = 1'b1;
            if (r_fill == FILL_NEAR1) begin
                // The buffer is full: hand it to the back and drop the rest of the item.
                o_push.valid     = 1'b1;
                o_push.desc.len  = r_fill + FILL_W'(1);
                n_busy[r_active] = 1'b1;
                n_active         = !r_active;
                n_fill           = '0;
                n_op_cnt         = 2'd0;
            end else begin
                n_fill   = r_fill + FILL_W'(1);
                n_op_b0  = r_op_b1;
                n_op_cnt = r_op_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= HDR_FIRST_RST;
            r_hdr_second <= HDR_SECOND_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_HDR_FIRST:  r_hdr_first  <= i_cfg_data;
                CFG_HDR_SECOND: r_hdr_second <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_left     <= 8'd0;
            r_mode     <= MODE_IDLE;
            r_active   <= 1'b0;
            r_busy     <= 2'b00;
            r_op_flush <= 1'b0;
            r_op_cnt   <= 2'd0;
        end else begin
            r_fill     <= n_fill;
            r_left     <= n_left;
            r_mode     <= n_mode;
            r_active   <= n_active;
            r_busy     <= n_busy;
            r_op_flush <= n_op_flush;
            r_op_cnt   <= n_op_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held  <= n_held;
        r_op_b0 <= n_op_b0;
        r_op_b1 <= n_op_b1;
    end

endmodule

// ----- design/hdfa_queue.sv -----
// Two-entry queue of message descriptors (bank and length) between the
// front and the back of the frame assembler. Depends on hdfa_pkg.
`timescale 1ns / 1ps

module hdfa_queue import hdfa_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output t_desc o_head,
    output logic  o_not_empty
);

    t_desc      r_entry [0:1];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_head      = r_entry[r_rd_ptr];
    assign o_not_empty = (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_entry[r_wr_ptr] <= i_push.desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- design/hdfa_back.sv -----
// Back part of the frame assembler: holds the two buffer banks and drains a
// finished message byte by byte to the output channel. Depends on hdfa_pkg.
`timescale 1ns / 1ps

module hdfa_back import hdfa_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mem_wr              i_mem_wr,
    input  t_desc                i_head,
    input  logic                 i_not_empty,
    output logic                 o_pop,
    output t_release             o_release,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_msg_byte,
    output logic                 o_msg_last,
    output logic [MSG_LEN_W-1:0] o_msg_length
);

    logic [7:0]           r_mem [0:MEM_DEPTH-1];
    logic [7:0]           r_rd_data;
    t_back_state          r_state, n_state;
    logic                 r_bank, n_bank;
    logic [FILL_W-1:0]    r_len, n_len;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_out_valid, n_out_valid;
    logic [7:0]           r_msg_byte, n_msg_byte;
    logic                 r_msg_last, n_msg_last;
    logic [MSG_LEN_W-1:0] r_msg_length, n_msg_length;
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 out_free;
    logic                 last;

    assign out_free     = !r_out_valid || !i_out_stall;
    assign last         = (FILL_W'(r_idx) + FILL_W'(1)) == r_len;
    assign o_out_valid  = r_out_valid;
    assign o_msg_byte   = r_msg_byte;
    assign o_msg_last   = r_msg_last;
    assign o_msg_length = r_msg_length;

    always_comb begin
        n_state      = r_state;
        n_bank       = r_bank;
        n_len        = r_len;
        n_idx        = r_idx;
        n_out_valid  = r_out_valid;
        n_msg_byte   = r_msg_byte;
        n_msg_last   = r_msg_last;
        n_msg_length = r_msg_length;
        rd_en        = 1'b0;
        rd_addr      = {r_bank, r_idx};
        o_pop        = 1'b0;
        o_release.valid = 1'b0;
        o_release.bank  = r_bank;

        if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            BK_IDLE: begin
                if (i_not_empty) begin
                    o_pop   = 1'b1;
                    n_bank  = i_head.bank;
                    n_len   = i_head.len;
                    n_idx   = '0;
                    n_state = BK_READ;
                end
            end
            BK_READ: begin
                rd_en   = 1'b1;
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_msg_byte   = r_rd_data;
                    n_msg_last   = last;
                    n_msg_length = MSG_LEN_W'(r_len);
                    if (last) begin
                        // The bank's contents now sit in the output register.
                        o_release.valid = 1'b1;
                        n_state         = BK_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = {r_bank, r_idx + IDX_W'(1)};
                        n_idx   = r_idx + IDX_W'(1);
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.en) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bank       <= n_bank;
        r_len        <= n_len;
        r_idx        <= n_idx;
        r_msg_byte   <= n_msg_byte;
        r_msg_last   <= n_msg_last;
        r_msg_length <= n_msg_length;
    end

endmodule

// ----- design/hdfa_checker.sv -----
// Port-level checker for the header-delimited frame assembler and the bind
// that attaches it to the top level. Depends on hdfa_pkg.
`timescale 1ns / 1ps

module hdfa_checker import hdfa_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic [7:0]           o_msg_byte,
    input logic                 o_msg_last,
    input logic [MSG_LEN_W-1:0] o_msg_length
);

    // A stalled output transaction stays offered with the same payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_msg_byte) && $stable(o_msg_last)
            && $stable(o_msg_length))
        else $error("stalled output transaction changed");

    // Right after reset nothing is offered and input is taken.
    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && !$past(i_rst_n) |-> !o_out_valid && !o_in_stall)
        else $error("block not quiet after reset");

    // Bytes of one message all carry the same length.
    a_len_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_msg_last) ##1 o_out_valid |->
            o_msg_length == $past(o_msg_length))
        else $error("message length changed inside a message");

endmodule

bind header_delimited_frame_assembler hdfa_checker u_hdfa_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_msg_byte   (o_msg_byte),
    .o_msg_last   (o_msg_last),
    .o_msg_length (o_msg_length)
);
